>>> hdl/tfbp_pkg.sv
// shared types and constants for the telemetry frame bit packer
package tfbp_pkg;

	localparam int DEF_FRAME_BYTES    = 256;
	localparam int DEF_CALLSIGN_BYTES = 6;
	localparam int DEF_QUEUE_DEPTH    = 2;
	localparam int CALLSIGN_MAX       = 6;
	localparam int FIELD_MAX_BITS     = 32;
	localparam int CALLSIGN_W         = 8 * CALLSIGN_MAX;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_FIELD = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;

	localparam logic [1:0] JOB_START = 2'd0;
	localparam logic [1:0] JOB_FIELD = 2'd1;
	localparam logic [1:0] JOB_END   = 2'd2;

	// one unit of work handed from front to back
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] data;   // delta time, packed field bytes or pad byte
		logic [2:0]  nbytes; // field bytes, 1 to 4
		logic        bvalid; // end item carries a real byte
		logic        err;    // error flag after the item
	} job_t;

endpackage

>>> hdl/telemetry_frame_bit_packer_core.sv
// top level of the telemetry frame bit packer
// builds a telemetry frame as a byte stream, bits packed lsb first. a start item sends
// min(CALLSIGN_BYTES,6) callsign bytes from the configuration register and then the
// 16-bit delta time, low byte first; a field item appends a sign bit and field_bits-1
// magnitude bits (widths above 32 count as 32, width 0 or a disabled field adds nothing)
// and sends every byte it completes; an end item sends the padded partial byte, or a
// result with byte_valid low when nothing is pending or the frame is in error, always
// with tlast high. a field that would push the frame past FRAME_BYTES bytes is dropped,
// the error flag is raised, no further field bytes are sent until the next start or end
// and the end result reports it. the front part accepts one item per cycle while the job
// queue has room, updating the bit stream state in that cycle; the back part drains the
// queue through a single byte-wide output register, one result per cycle while the
// receiver is ready. a start item thus yields min(CALLSIGN_BYTES,6)+2 results (8 by
// default), a field 0 to 4, an end one; the output register sets the sustained rate.
// the first result of an item is written into the job queue and then loaded into the
// output register once that is free. the user writes the callsign register through
// cfg_valid/cfg_ready (always ready) only while idle; the block does not enforce this
module telemetry_frame_bit_packer_core import tfbp_pkg::*; #(
	parameter int FRAME_BYTES    = DEF_FRAME_BYTES,
	parameter int CALLSIGN_BYTES = DEF_CALLSIGN_BYTES,
	parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel: station_callsign, first byte in bits 7:0
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CALLSIGN_W-1:0] cfg_data,
	// item input
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// elapsed_ms [15:0], field_value [47:16], field_bits [53:48], field_enable [54], zero [55]
	input  logic [55:0]           s_tdata,
	// operation [1:0]
	input  logic [1:0]            s_tuser,
	// result output
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// byte_out [7:0]
	output logic [7:0]            m_tdata,
	// byte_valid [0], frame_error [1]
	output logic [1:0]            m_tuser,
	// frame_last
	output logic                  m_tlast
);

	logic [CALLSIGN_W-1:0] callsign_q;

	logic item_take;
	logic push;
	job_t push_job;
	logic pop;
	job_t head_job;
	logic head_valid;
	logic q_full;

	// configuration register, taken at any time the handshake completes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			callsign_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			callsign_q <= cfg_data;
		end
	end

	// an item is taken whenever the queue can hold whatever job it may raise
	assign s_tready  = !q_full;
	assign item_take = s_tvalid && s_tready;

	tfbp_front #(
		.FRAME_BYTES    (FRAME_BYTES),
		.CALLSIGN_BYTES (CALLSIGN_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_take    (item_take),
		.operation    (s_tuser),
		.elapsed_ms   (s_tdata[15:0]),
		.field_value  (s_tdata[47:16]),
		.field_bits   (s_tdata[53:48]),
		.field_enable (s_tdata[54]),
		.push         (push),
		.push_job     (push_job)
	);

	// jobs wait here so the input and output sides stall independently
	tfbp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.head_job  (head_job),
		.not_empty (head_valid),
		.full      (q_full)
	);

	tfbp_back #(
		.CALLSIGN_BYTES (CALLSIGN_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_job   (head_job),
		.head_valid (head_valid),
		.callsign   (callsign_q),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

>>> hdl/tfbp_queue.sv
// short job queue between front and back
module tfbp_queue import tfbp_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head_job,
	output logic not_empty,
	output logic full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign head_job  = slot_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> hdl/tfbp_front.sv
// front end: takes items, keeps the bit stream state and issues jobs
module tfbp_front import tfbp_pkg::*; #(
	parameter int FRAME_BYTES    = DEF_FRAME_BYTES,
	parameter int CALLSIGN_BYTES = DEF_CALLSIGN_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_take,
	input  logic [1:0]  operation,
	input  logic [15:0] elapsed_ms,
	input  logic [31:0] field_value,
	input  logic [5:0]  field_bits,
	input  logic        field_enable,
	output logic        push,
	output job_t        push_job
);

	localparam int NCS        = (CALLSIGN_BYTES > CALLSIGN_MAX) ? CALLSIGN_MAX : CALLSIGN_BYTES;
	localparam int SENT_W     = $clog2(FRAME_BYTES + 1);
	localparam int TOT_W      = SENT_W + 4;
	localparam int LIMIT_BITS = FRAME_BYTES * 8;

	logic [6:0]        partial_q;
	logic [2:0]        pcount_q;
	logic [SENT_W-1:0] sent_q;
	logic              ovf_q;

	logic [5:0]       n_eff;
	logic [TOT_W-1:0] total;
	logic             over;
	logic             sign;
	logic [31:0]      mag;
	logic [31:0]      mask;
	logic [31:0]      bits;
	logic [38:0]      acc;
	logic [38:0]      rest;
	logic [5:0]       count;
	logic [2:0]       nb;
	logic             fld_go;
	logic             end_valid;

	always_comb begin
		n_eff     = (field_bits > 6'(FIELD_MAX_BITS)) ? 6'(FIELD_MAX_BITS) : field_bits;
		total     = TOT_W'({sent_q, 3'b000}) + TOT_W'(pcount_q) + TOT_W'(n_eff);
		over      = (total > TOT_W'(LIMIT_BITS));
		sign      = field_value[31];
		mag       = sign ? (~field_value + 32'd1) : field_value;
		// low n-1 magnitude bits survive
		mask      = 32'hFFFF_FFFF >> (6'd33 - n_eff);
		bits      = {mag[30:0] & mask[30:0], sign};
		acc       = {32'd0, partial_q} | ({7'd0, bits} << pcount_q);
		count     = {3'b000, pcount_q} + n_eff;
		nb        = count[5:3];
		rest      = acc >> {nb, 3'b000};
		fld_go    = field_enable && (field_bits != 6'd0) && !ovf_q;
		end_valid = (pcount_q != 3'd0) && !ovf_q;

		push_job        = '0;
		push            = 1'b0;
		push_job.err    = 1'b0;
		case (operation)
			OP_START: begin
				push_job.kind = JOB_START;
				push_job.data = {16'd0, elapsed_ms};
				push          = item_take;
			end
			OP_FIELD: begin
				push_job.kind   = JOB_FIELD;
				push_job.data   = acc[31:0];
				push_job.nbytes = nb;
				push            = item_take && fld_go && !over && (nb != 3'd0);
			end
			OP_END: begin
				push_job.kind   = JOB_END;
				push_job.data   = end_valid ? {25'd0, partial_q} : 32'd0;
				push_job.bvalid = end_valid;
				push_job.err    = ovf_q;
				push            = item_take;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			pcount_q  <= '0;
			sent_q    <= '0;
			ovf_q     <= 1'b0;
		end else if (item_take) begin
			case (operation)
				OP_START: begin
					partial_q <= '0;
					pcount_q  <= '0;
					sent_q    <= SENT_W'(NCS + 2);
					ovf_q     <= 1'b0;
				end
				OP_FIELD: begin
					if (fld_go) begin
						if (over) begin
							ovf_q <= 1'b1;
						end else begin
							partial_q <= rest[6:0];
							pcount_q  <= count[2:0];
							sent_q    <= sent_q + SENT_W'(nb);
						end
					end
				end
				OP_END: begin
					partial_q <= '0;
					pcount_q  <= '0;
					sent_q    <= '0;
					ovf_q     <= 1'b0;
				end
				default: begin
					ovf_q <= ovf_q;
				end
			endcase
		end
	end

endmodule

>>> hdl/tfbp_back.sv
// back end: turns queued jobs into output bytes, one per cycle while the receiver is ready
module tfbp_back import tfbp_pkg::*; #(
	parameter int CALLSIGN_BYTES = DEF_CALLSIGN_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  job_t                  head_job,
	input  logic                  head_valid,
	input  logic [CALLSIGN_W-1:0] callsign,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,
	output logic [1:0]            m_tuser,
	output logic                  m_tlast
);

	localparam int NCS = (CALLSIGN_BYTES > CALLSIGN_MAX) ? CALLSIGN_MAX : CALLSIGN_BYTES;

	logic [2:0]            idx_q;
	logic                  m_valid_q;
	logic [7:0]            m_data_q;
	logic [1:0]            m_user_q;
	logic                  m_last_q;

	logic                  load;
	logic [2:0]            last_idx;
	logic                  at_last;
	logic [7:0]            byte_sel;
	logic [CALLSIGN_W-1:0] cs_shift;
	logic [31:0]           fld_shift;
	logic                  bvalid;

	always_comb begin
		cs_shift  = callsign >> {idx_q, 3'b000};
		fld_shift = head_job.data >> {idx_q[1:0], 3'b000};
		bvalid    = 1'b1;
		case (head_job.kind)
			JOB_START: begin
				last_idx = 3'(NCS + 1);
				if (idx_q < 3'(NCS)) begin
					byte_sel = cs_shift[7:0];
				end else if (idx_q == 3'(NCS)) begin
					byte_sel = head_job.data[7:0];
				end else begin
					byte_sel = head_job.data[15:8];
				end
			end
			JOB_FIELD: begin
				last_idx = head_job.nbytes - 3'd1;
				byte_sel = fld_shift[7:0];
			end
			default: begin
				last_idx = 3'd0;
				byte_sel = head_job.data[7:0];
				bvalid   = head_job.bvalid;
			end
		endcase
		load    = head_valid && (!m_valid_q || m_tready);
		at_last = (idx_q == last_idx);
		pop     = load && at_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q     <= at_last ? 3'd0 : idx_q + 3'd1;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_data_q <= byte_sel;
			m_user_q <= {head_job.err, bvalid};
			m_last_q <= (head_job.kind == JOB_END);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

endmodule

>>> sim/tb_telemetry_frame_bit_packer_core.sv
// self-checking testbench for the telemetry frame bit packer, predicting every frame byte
`timescale 1ns / 100ps

module tb_telemetry_frame_bit_packer_core;
	import tfbp_pkg::*;

	// operation code the block must ignore
	localparam logic [1:0] OP_UNDEFINED = 2'd3;
	// callsign bytes actually sent, the register only holds six
	localparam int CS_BYTES      = (DEF_CALLSIGN_BYTES < CALLSIGN_MAX) ?
		DEF_CALLSIGN_BYTES : CALLSIGN_MAX;
	// cycles for the pipeline to settle once the last byte has gone
	localparam int SETTLE_CYCLES = DEF_CALLSIGN_BYTES + 2;
	localparam int RANDOM_ITEMS  = 480;
	// cycles without any handshake before the run is declared hung
	localparam int IDLE_LIMIT    = 2000;

	// byte-level predictor of the frame builder plus queue of bytes still owed
	class frame_scoreboard;
		typedef struct packed {
			logic [7:0] data;
			logic       valid;
			logic       last;
			logic       err;
		} frame_byte_t;

		frame_byte_t           expected_bytes[$];
		logic [CALLSIGN_W-1:0] callsign;
		logic [6:0]            pend_bits;
		logic [2:0]            pend_count;
		logic [8:0]            frame_len;
		logic                  overflow;
		int                    errors;
		int                    items;
		int                    results;
		int                    frames;
		int                    overflows;

		function new();
			callsign  = '0;
			errors    = 0;
			items     = 0;
			results   = 0;
			frames    = 0;
			overflows = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			pend_bits  = '0;
			pend_count = '0;
			frame_len  = '0;
			overflow   = 1'b0;
		endfunction

		function void queue_byte(input logic [7:0] data, input logic valid, input logic last);
			frame_byte_t b;
			b.data  = data;
			b.valid = valid;
			b.last  = last;
			b.err   = overflow;
			expected_bytes.push_back(b);
		endfunction

		function void note_item(input logic [1:0] op, input logic [15:0] dt,
				input logic [31:0] val, input logic [5:0] nbits, input logic en);
			int          width;
			int          cnt;
			logic        sign;
			logic [31:0] mag;
			logic [63:0] mask;
			logic [63:0] code;
			logic [63:0] acc;
			items++;
			case (op)
				OP_START: begin
					clear_frame();
					for (int i = 0; i < CS_BYTES; i++) begin
						queue_byte(callsign[8*i +: 8], 1'b1, 1'b0);
						frame_len++;
					end
					queue_byte(dt[7:0], 1'b1, 1'b0);
					queue_byte(dt[15:8], 1'b1, 1'b0);
					frame_len += 2;
				end
				OP_FIELD: begin
					if (!en || nbits == 0 || overflow)
						return;
					width = (nbits > FIELD_MAX_BITS) ? FIELD_MAX_BITS : int'(nbits);
					// a field that would run past the frame limit is dropped
					if (int'(frame_len) * 8 + int'(pend_count) + width > DEF_FRAME_BYTES * 8) begin
						overflow = 1'b1;
						overflows++;
						return;
					end
					sign = val[31];
					mag  = sign ? (32'd0 - val) : val;
					mask = (64'd1 << (width - 1)) - 64'd1;
					code = (({32'd0, mag} & mask) << 1) | {63'd0, sign};
					acc  = {57'd0, pend_bits} | (code << pend_count);
					cnt  = int'(pend_count) + width;
					while (cnt >= 8) begin
						queue_byte(acc[7:0], 1'b1, 1'b0);
						frame_len++;
						acc = acc >> 8;
						cnt -= 8;
					end
					pend_bits  = acc[6:0];
					pend_count = cnt[2:0];
				end
				OP_END: begin
					frames++;
					if (pend_count != 0 && !overflow)
						queue_byte({1'b0, pend_bits}, 1'b1, 1'b1);
					else
						queue_byte(8'd0, 1'b0, 1'b1);
					clear_frame();
				end
				default: ;
			endcase
		endfunction

		function void check_result(input logic [7:0] data, input logic valid,
				input logic last, input logic err);
			frame_byte_t want;
			if (expected_bytes.size() == 0) begin
				$error("result with nothing pending: byte_out %02h byte_valid %0b", data, valid);
				errors++;
				return;
			end
			want = expected_bytes.pop_front();
			results++;
			if (want.data !== data) begin
				$error("byte_out expected %02h actual %02h", want.data, data);
				errors++;
			end
			if (want.valid !== valid) begin
				$error("byte_valid expected %0b actual %0b", want.valid, valid);
				errors++;
			end
			if (want.last !== last) begin
				$error("frame_last expected %0b actual %0b", want.last, last);
				errors++;
			end
			if (want.err !== err) begin
				$error("frame_error expected %0b actual %0b", want.err, err);
				errors++;
			end
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CALLSIGN_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	// elapsed_ms [15:0], field_value [47:16], field_bits [53:48], field_enable [54], zero [55]
	logic [55:0]           s_tdata   = '0;
	// operation [1:0]
	logic [1:0]            s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	// byte_out [7:0]
	logic [7:0]            m_tdata;
	// byte_valid [0], frame_error [1]
	logic [1:0]            m_tuser;
	logic                  m_tlast;

	frame_scoreboard sb;
	int              burst_left    = 0;
	int              cfg_writes    = 0;
	int              idle_cycles   = 0;
	logic [15:0]     ready_pattern = '1;
	int              pattern_age   = 0;

	telemetry_frame_bit_packer_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver back-pressure: a 16-bit ready pattern rotated each cycle, swapped when pattern_age runs out
	// patterns always hold at least one ready bit so the receiver never stalls indefinitely
	always @(posedge clk) begin
		if (pattern_age == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pattern <= '1;
				1: ready_pattern <= 16'($urandom) | 16'h0001;
				2: ready_pattern <= 16'h00FF;
				default: ready_pattern <= 16'h5555;
			endcase
			pattern_age <= 64;
		end else begin
			ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
			pattern_age   <= pattern_age - 1;
		end
		m_tready <= ready_pattern[15];
	end

	// every result is checked against the oldest byte still owed
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
	end

	// hang detection: count cycles in which no channel moves anything
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	// hand one item over, then keep the sender's burst and gap rhythm
	task automatic send_item(input logic [1:0] op, input logic [15:0] dt,
			input logic [31:0] val, input logic [5:0] nbits, input logic en);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, en, nbits, val, dt};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		sb.note_item(op, dt, val, nbits, en);
		burst_left--;
		if (burst_left <= 0) begin
			// occasional long bursts give stretches with no idling at all
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// field item with random content; wide fields are used to fill a frame up to its limit
	task automatic random_field(input bit wide);
		logic [31:0] val;
		logic [5:0]  nbits;
		logic        en;
		case ($urandom_range(0, 7))
			0: val = 32'h8000_0000;
			1: val = 32'h7FFF_FFFF;
			2: val = 32'hFFFF_FFFF;
			3: val = 32'h0000_0000;
			default: val = $urandom;
		endcase
		if (wide)
			nbits = 6'($urandom_range(26, 40));
		else if ($urandom_range(0, 7) == 0)
			nbits = 6'($urandom_range(0, 63));
		else
			nbits = 6'($urandom_range(1, 32));
		en = wide ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 9) != 0);
		send_item(OP_FIELD, 16'($urandom_range(0, 16'hFFFF)), val, nbits, en);
	endtask

	// callsign register is only written once the block has drained
	task automatic write_callsign(input logic [CALLSIGN_W-1:0] value);
		s_tvalid <= 1'b0;
		while (sb.expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.callsign = value;
		cfg_writes++;
	endtask

	initial begin
		logic [CALLSIGN_W-1:0] cs;
		int                    kind;
		int                    total;
		int                    frames_since_cfg;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed part
		write_callsign('1);
		// field and end arriving with no start before them
		send_item(OP_FIELD, 16'h0000, 32'h7FFF_FFFF, 6'd32, 1'b1);
		send_item(OP_FIELD, 16'h0000, 32'h0000_0005, 6'd3, 1'b1);
		send_item(OP_END, 16'h0000, 32'h0, 6'd0, 1'b0);
		// end with nothing pending gives a result with no byte
		send_item(OP_END, 16'hFFFF, 32'hFFFF_FFFF, 6'd63, 1'b1);
		send_item(OP_START, 16'hFFFF, 32'h0, 6'd0, 1'b0);
		// sign bit only
		send_item(OP_FIELD, 16'h0000, 32'hFFFF_FFFF, 6'd1, 1'b1);
		// most negative value, magnitude wraps to its low bits
		send_item(OP_FIELD, 16'h0000, 32'h8000_0000, 6'd32, 1'b1);
		send_item(OP_FIELD, 16'hFFFF, 32'h7FFF_FFFF, 6'd32, 1'b1);
		// zero width adds nothing
		send_item(OP_FIELD, 16'h0000, 32'h1234_5678, 6'd0, 1'b1);
		// oversize width is clamped to 32
		send_item(OP_FIELD, 16'h0000, 32'hDEAD_BEEF, 6'd63, 1'b1);
		// disabled field is skipped
		send_item(OP_FIELD, 16'h0000, 32'hCAFE_F00D, 6'd17, 1'b0);
		send_item(OP_UNDEFINED, 16'hFFFF, 32'hFFFF_FFFF, 6'd63, 1'b1);
		send_item(OP_FIELD, 16'h0000, 32'h0000_0000, 6'd7, 1'b1);
		send_item(OP_END, 16'h0000, 32'h0, 6'd0, 1'b0);
		write_callsign(48'hA55A_C33C_0FF0);
		send_item(OP_START, 16'h0000, 32'h0, 6'd0, 1'b0);
		send_item(OP_FIELD, 16'h0000, 32'hFFFF_FFFB, 6'd8, 1'b1);
		send_item(OP_FIELD, 16'h0000, 32'h0000_0002, 6'd3, 1'b1);
		send_item(OP_END, 16'h0000, 32'h0, 6'd0, 1'b0);

		// random part: mostly well-formed frames, some long enough to hit the byte limit
		write_callsign('0);
		frames_since_cfg = 0;
		total = sb.items + RANDOM_ITEMS;
		while (sb.items < total) begin
			if (frames_since_cfg >= 12) begin
				case ($urandom_range(0, 3))
					0: cs = '0;
					1: cs = '1;
					default: begin
						cs[31:0]  = $urandom;
						cs[47:32] = 16'($urandom_range(0, 16'hFFFF));
					end
				endcase
				write_callsign(cs);
				frames_since_cfg = 0;
			end
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				// noise: any operation, undefined one included, in any order
				repeat ($urandom_range(1, 4))
					send_item(2'($urandom_range(0, 3)), 16'($urandom_range(0, 16'hFFFF)),
						$urandom, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
			end else begin
				send_item(OP_START, 16'($urandom_range(0, 16'hFFFF)), $urandom,
					6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
				repeat ((kind == 1) ? $urandom_range(58, 70) : $urandom_range(0, 8))
					random_field(kind == 1);
				// now and then a frame is left without its end
				if ($urandom_range(0, 15) != 0)
					send_item(OP_END, 16'($urandom_range(0, 16'hFFFF)), $urandom,
						6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
			end
			frames_since_cfg++;
		end
		s_tvalid <= 1'b0;

		while (sb.expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES * 4) @(posedge clk);
		if (sb.expected_bytes.size() != 0)
			$error("%0d expected results never arrived", sb.expected_bytes.size());

		$display("run: %0d items, %0d frames closed, %0d results checked",
			sb.items, sb.frames, sb.results);
		$display("run: %0d frames overran the byte limit, %0d callsign writes",
			sb.overflows, cfg_writes);
		if (sb.errors == 0 && sb.expected_bytes.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> telemetry_frame_bit_packer_core.f
hdl/tfbp_pkg.sv
hdl/tfbp_queue.sv
hdl/tfbp_front.sv
hdl/tfbp_back.sv
hdl/telemetry_frame_bit_packer_core.sv
sim/tb_telemetry_frame_bit_packer_core.sv
